>>> rtl/seismogram_misfit_accumulator_top_macros.svh
// Assertion macros used by the misfit accumulator back end.
`ifndef SEISMOGRAM_MISFIT_ACCUMULATOR_TOP_MACROS_SVH
`define SEISMOGRAM_MISFIT_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SMACC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMACC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/smacc_pkg.sv
// Shared types and constants of the seismogram misfit accumulator.
`timescale 1ns / 1ps
`default_nettype none
package smacc_pkg;

    localparam int VAL_W       = 32;
    localparam int ACC_W       = 64;
    localparam int Q_SHIFT     = 30;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_NORM_MODE    = 2'd0;
    localparam logic [1:0] CFG_INTEGRATE    = 2'd1;
    localparam logic [1:0] CFG_DT_STEP      = 2'd2;
    localparam logic [1:0] CFG_START_MISFIT = 2'd3;

    localparam logic [15:0] DT_RESET = 16'hFFFF;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic                    norm_mode;
        logic                    integrate_enable;
        logic [15:0]             dt_step;
        logic signed [ACC_W-1:0] start_misfit;
    } smacc_cfg_t;

    // One classified item handed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] syn;
        logic signed [VAL_W-1:0] obs;
        logic                    killed;
        logic                    trace_end;
        logic                    shot_end;
    } smacc_item_t;

    // Saturating 64-bit add
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // Saturating 64-bit subtract
    function automatic logic signed [ACC_W-1:0] sat_sub(
        input logic signed [ACC_W-1:0] a, input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/seismogram_misfit_accumulator_top.sv
// Seismogram misfit accumulator: top level with configuration registers.
// Flow: front (an extra multiply step when integrating), then the queue, then the back
// sequencer (L2 or correlation sums per item); a correlation trace end adds 32 square root
// steps and 30 division steps, the division skipped when the coefficient saturates,
// before the misfit update. The back takes one item at a time.
// Reset (synchronous, active low) clears all sums, the queue and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
module seismogram_misfit_accumulator_top #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [63:0]                   cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_syn_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] s_obs_sample,
    input  wire logic                          s_trace_killed,
    input  wire logic                          s_last_in_trace,
    input  wire logic                          s_last_in_shot,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [63:0]                 m_misfit_value
);

    smacc_pkg::smacc_cfg_t  cfg_reg;
    smacc_pkg::smacc_item_t f_item, q_item;
    logic f_valid, f_ready, q_valid, q_ready;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.norm_mode        <= 1'b0;
            cfg_reg.integrate_enable <= 1'b0;
            cfg_reg.dt_step          <= smacc_pkg::DT_RESET;
            cfg_reg.start_misfit     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                smacc_pkg::CFG_NORM_MODE:    cfg_reg.norm_mode        <= cfg_data[0];
                smacc_pkg::CFG_INTEGRATE:    cfg_reg.integrate_enable <= cfg_data[0];
                smacc_pkg::CFG_DT_STEP:      cfg_reg.dt_step          <= cfg_data[15:0];
                smacc_pkg::CFG_START_MISFIT: cfg_reg.start_misfit     <= cfg_data;
                default: ;
            endcase
        end
    end

    smacc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_syn_sample    (s_syn_sample),
        .s_obs_sample    (s_obs_sample),
        .s_trace_killed  (s_trace_killed),
        .s_last_in_trace (s_last_in_trace),
        .s_last_in_shot  (s_last_in_shot),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .out_item        (f_item)
    );

    smacc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    smacc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_item        (q_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_misfit_value (m_misfit_value)
    );

endmodule
`default_nettype wire

>>> rtl/smacc_front.sv
// Front end: accepts samples, optionally integrates and scales them by dt, hands items on.
`timescale 1ns / 1ps
`default_nettype none
module smacc_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire smacc_pkg::smacc_cfg_t         cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_syn_sample,
    input  wire logic signed [SAMPLE_BITS-1:0] s_obs_sample,
    input  wire logic                          s_trace_killed,
    input  wire logic                          s_last_in_trace,
    input  wire logic                          s_last_in_shot,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output smacc_pkg::smacc_item_t             out_item
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                 state_reg, state_next;
    logic signed [39:0]      syn_sum_reg, syn_sum_next, obs_sum_reg, obs_sum_next;
    logic signed [56:0]      syn_prod_reg, obs_prod_reg;
    logic signed [smacc_pkg::VAL_W-1:0] syn_val_reg, obs_val_reg;
    logic                    killed_reg, te_reg, se_reg, integ_reg;
    logic signed [40:0]      syn_run, obs_run;
    logic signed [16:0]      dt_s;

    // 40-bit running sum saturation
    function automatic logic signed [39:0] run_sat(input logic signed [40:0] x);
        if (x[40] != x[39]) return x[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
        return x[39:0];
    endfunction

    // floor(p / 2^16) saturated to 32 bits
    function automatic logic signed [31:0] scale_sat(input logic signed [56:0] p);
        logic signed [40:0] q;
        q = p[56:16];
        if (q > 41'sh0007FFFFFFF) return {1'b0, {31{1'b1}}};
        if (q < -41'sh00080000000) return {1'b1, 31'd0};
        return q[31:0];
    endfunction

    assign syn_run = {syn_sum_reg[39], syn_sum_reg} + 41'(s_syn_sample);
    assign obs_run = {obs_sum_reg[39], obs_sum_reg} + 41'(s_obs_sample);
    assign dt_s    = $signed({1'b0, cfg.dt_step});

    assign s_ready   = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_PUSH);
    always_comb begin
        out_item.syn       = integ_reg ? scale_sat(syn_prod_reg) : syn_val_reg;
        out_item.obs       = integ_reg ? scale_sat(obs_prod_reg) : obs_val_reg;
        out_item.killed    = killed_reg;
        out_item.trace_end = te_reg;
        out_item.shot_end  = se_reg;
    end

    // Sequencing and running sums
    always_comb begin
        state_next   = state_reg;
        syn_sum_next = syn_sum_reg;
        obs_sum_next = obs_sum_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    if (cfg.integrate_enable) begin
                        syn_sum_next = run_sat(syn_run);
                        obs_sum_next = run_sat(obs_run);
                        state_next   = F_MUL;
                    end else begin
                        if (s_last_in_trace || s_last_in_shot) begin
                            syn_sum_next = '0;
                            obs_sum_next = '0;
                        end
                        state_next = F_PUSH;
                    end
                end
            end
            F_MUL: begin
                if (te_reg) begin
                    syn_sum_next = '0;
                    obs_sum_next = '0;
                end
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (out_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            syn_sum_reg <= '0;
            obs_sum_reg <= '0;
        end else begin
            state_reg   <= state_next;
            syn_sum_reg <= syn_sum_next;
            obs_sum_reg <= obs_sum_next;
        end
    end

    // Payload capture and dt scaling products
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            syn_val_reg <= 32'(s_syn_sample);
            obs_val_reg <= 32'(s_obs_sample);
            killed_reg  <= s_trace_killed;
            te_reg      <= s_last_in_trace || s_last_in_shot;
            se_reg      <= s_last_in_shot;
            integ_reg   <= cfg.integrate_enable;
        end
        if (state_reg == F_MUL) begin
            syn_prod_reg <= syn_sum_reg * dt_s;
            obs_prod_reg <= obs_sum_reg * dt_s;
        end
    end

endmodule
`default_nettype wire

>>> rtl/smacc_queue.sv
// Two-entry item queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module smacc_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire smacc_pkg::smacc_item_t in_item,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output smacc_pkg::smacc_item_t      out_item
);

    smacc_pkg::smacc_item_t entry_reg [smacc_pkg::QUEUE_DEPTH];
    logic [smacc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [smacc_pkg::QUEUE_PTR_W:0]   count_reg;
    logic push, pop;

    assign in_ready  = (count_reg != (smacc_pkg::QUEUE_PTR_W + 1)'(smacc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule
`default_nettype wire

>>> rtl/smacc_back.sv
// Back end: misfit sums, square roots, coefficient division, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "seismogram_misfit_accumulator_top_macros.svh"
module smacc_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire smacc_pkg::smacc_cfg_t  cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire smacc_pkg::smacc_item_t in_item,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [63:0]          m_misfit_value
);

    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001,
        B_MUL  = 8'b00000010,
        B_ACC  = 8'b00000100,
        B_SQI  = 8'b00001000,
        B_SQRT = 8'b00010000,
        B_DIV  = 8'b00100000,
        B_COEF = 8'b01000000,
        B_FIN  = 8'b10000000
    } bstate_t;

    typedef enum logic [2:0] {
        SEL_DIFF, SEL_XO, SEL_SS, SEL_OO, SEL_ROOT
    } sel_t;

    bstate_t            state_reg;
    sel_t               sel_reg;
    smacc_pkg::smacc_item_t item_reg;
    logic               shot_open_reg;
    logic signed [63:0] acc_reg, cross_reg, syn_e_reg, obs_e_reg;
    logic signed [67:0] prod_reg;
    logic [63:0]        n_s_reg, res_s_reg, n_o_reg, res_o_reg, bit_reg;
    logic [63:0]        d_reg;
    logic [64:0]        r_reg;
    logic               q0_reg, neg_reg;
    logic [smacc_pkg::Q_SHIFT-1:0] bits_reg;
    logic [4:0]         div_cnt_reg;
    logic               out_valid_reg;
    logic signed [63:0] out_data_reg;

    logic signed [33:0] mul_a, mul_b, diff;
    logic [31:0]        root_s, root_o;
    logic signed [63:0] sq_sat, c_sat, c_div;
    logic [63:0]        mag;
    logic [64:0]        r2;
    logic [63:0]        sum_s, sum_o;
    logic               out_free;

    assign in_ready       = (state_reg == B_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_misfit_value = out_data_reg;
    assign out_free       = !out_valid_reg || m_ready;

    // Shared multiplier operand select
    assign diff   = 34'(item_reg.syn) - 34'(item_reg.obs);
    assign root_s = (res_s_reg == '0) ? 32'd1 : res_s_reg[31:0];
    assign root_o = (res_o_reg == '0) ? 32'd1 : res_o_reg[31:0];
    always_comb begin
        case (sel_reg)
            SEL_DIFF: begin mul_a = diff;                 mul_b = diff;                 end
            SEL_XO:   begin mul_a = 34'(item_reg.syn);    mul_b = 34'(item_reg.obs);    end
            SEL_SS:   begin mul_a = 34'(item_reg.syn);    mul_b = 34'(item_reg.syn);    end
            SEL_OO:   begin mul_a = 34'(item_reg.obs);    mul_b = 34'(item_reg.obs);    end
            SEL_ROOT: begin mul_a = $signed({2'b0, root_s}); mul_b = $signed({2'b0, root_o}); end
            default:  begin mul_a = '0;                   mul_b = '0;                   end
        endcase
    end

    // Squared difference saturation, coefficient magnitude and saturation
    assign sq_sat = (prod_reg[67:63] != '0) ? smacc_pkg::ACC_MAX : prod_reg[63:0];
    assign mag    = cross_reg[63] ? (64'd0 - cross_reg) : cross_reg;
    assign c_sat  = neg_reg ? -64'sd2147483648 : 64'sd2147483647;
    assign c_div  = neg_reg ? -$signed(64'({q0_reg, bits_reg})) : $signed(64'({q0_reg, bits_reg}));
    assign r2     = {r_reg[63:0], 1'b0};

    // One bit-pair step of both integer square roots
    assign sum_s = res_s_reg + bit_reg;
    assign sum_o = res_o_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            shot_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            cross_reg     <= '0;
            syn_e_reg     <= '0;
            obs_e_reg     <= '0;
            sel_reg       <= SEL_DIFF;
        end else begin
            // Result valid: set on a shot end, cleared once taken
            if (state_reg == B_FIN && item_reg.shot_end && out_free) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE: begin
                    if (in_valid) begin
                        if (!shot_open_reg) begin
                            acc_reg       <= cfg.start_misfit;
                            shot_open_reg <= 1'b1;
                        end
                        sel_reg   <= cfg.norm_mode ? SEL_XO : SEL_DIFF;
                        state_reg <= B_MUL;
                    end
                end
                B_MUL: state_reg <= B_ACC;
                B_ACC: begin
                    case (sel_reg)
                        SEL_DIFF: begin
                            if (!item_reg.killed) acc_reg <= smacc_pkg::sat_add(acc_reg, sq_sat);
                            state_reg <= B_FIN;
                        end
                        SEL_XO: begin
                            cross_reg <= smacc_pkg::sat_add(cross_reg, prod_reg[63:0]);
                            sel_reg   <= SEL_SS;
                            state_reg <= B_MUL;
                        end
                        SEL_SS: begin
                            syn_e_reg <= smacc_pkg::sat_add(syn_e_reg, prod_reg[63:0]);
                            sel_reg   <= SEL_OO;
                            state_reg <= B_MUL;
                        end
                        SEL_OO: begin
                            obs_e_reg <= smacc_pkg::sat_add(obs_e_reg, prod_reg[63:0]);
                            state_reg <= (item_reg.trace_end && !item_reg.killed) ? B_SQI : B_FIN;
                        end
                        SEL_ROOT: begin
                            if ({1'b0, mag} >= {prod_reg[63:0], 1'b0}) begin
                                acc_reg   <= smacc_pkg::sat_sub(acc_reg, c_sat);
                                state_reg <= B_FIN;
                            end else begin
                                state_reg <= B_DIV;
                            end
                        end
                        default: state_reg <= B_FIN;
                    endcase
                end
                B_SQI: state_reg <= B_SQRT;
                B_SQRT: begin
                    if (bit_reg == 64'd1) begin
                        sel_reg   <= SEL_ROOT;
                        state_reg <= B_MUL;
                    end
                end
                B_DIV: begin
                    if (div_cnt_reg == '0) state_reg <= B_COEF;
                end
                B_COEF: begin
                    acc_reg   <= smacc_pkg::sat_sub(acc_reg, c_div);
                    state_reg <= B_FIN;
                end
                B_FIN: begin
                    if (!item_reg.shot_end || out_free) begin
                        if (item_reg.trace_end) begin
                            cross_reg <= '0;
                            syn_e_reg <= '0;
                            obs_e_reg <= '0;
                        end
                        if (item_reg.shot_end) begin
                            shot_open_reg <= 1'b0;
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // Datapath registers without reset
    always_ff @(posedge aclk) begin
        if (state_reg == B_IDLE && in_valid) item_reg <= in_item;
        if (state_reg == B_MUL) prod_reg <= mul_a * mul_b;
        if (state_reg == B_FIN && item_reg.shot_end && out_free) out_data_reg <= acc_reg;
        if (state_reg == B_ACC && sel_reg == SEL_ROOT) begin
            d_reg   <= prod_reg[63:0];
            neg_reg <= cross_reg[63];
            q0_reg  <= (mag >= prod_reg[63:0]);
            r_reg   <= {1'b0, (mag >= prod_reg[63:0]) ? (mag - prod_reg[63:0]) : mag};
            div_cnt_reg <= 5'(smacc_pkg::Q_SHIFT - 1);
        end
        if (state_reg == B_SQI) begin
            n_s_reg   <= syn_e_reg;
            n_o_reg   <= obs_e_reg;
            res_s_reg <= '0;
            res_o_reg <= '0;
            bit_reg   <= 64'd1 << 62;
        end
        if (state_reg == B_SQRT) begin
            if (n_s_reg >= sum_s) begin
                n_s_reg   <= n_s_reg - sum_s;
                res_s_reg <= (res_s_reg >> 1) + bit_reg;
            end else begin
                res_s_reg <= res_s_reg >> 1;
            end
            if (n_o_reg >= sum_o) begin
                n_o_reg   <= n_o_reg - sum_o;
                res_o_reg <= (res_o_reg >> 1) + bit_reg;
            end else begin
                res_o_reg <= res_o_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == B_DIV) begin
            if (r2 >= {1'b0, d_reg}) begin
                r_reg    <= r2 - {1'b0, d_reg};
                bits_reg <= {bits_reg[smacc_pkg::Q_SHIFT-2:0], 1'b1};
            end else begin
                r_reg    <= r2;
                bits_reg <= {bits_reg[smacc_pkg::Q_SHIFT-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    `SMACC_ASSERT_SAME(a_sqrt_bit_live, state_reg == B_SQRT, bit_reg != '0,
        "square root step with no bit left")
    `SMACC_ASSERT_SAME(a_div_rem_below, state_reg == B_DIV, r_reg < {1'b0, d_reg},
        "division remainder not below divisor")
    `SMACC_ASSERT_NEXT(a_result_stall,
        state_reg == B_FIN && item_reg.shot_end && out_valid_reg && !m_ready,
        state_reg == B_FIN, "result overwritten while still pending")

endmodule
`default_nettype wire
